// ----- rtl/asf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package asf_pkg;

	// Store geometry
	localparam int MAX_ACT   = 32;
	localparam int IDX_W     = $clog2(MAX_ACT);
	localparam int CNT_W     = $clog2(MAX_ACT + 1);
	localparam int TIME_W    = 16;
	localparam int SELCNT_W  = 6;

	// Result error codes
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_ORDER = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ERR,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan_step;
		logic emit_init;
		logic emit_step;
		logic err_emit;
		logic clear;
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic run_bad;
		logic scan_done;
		logic emit_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/asf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module asf_ctrl import asf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     last,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd,
	output logic          busy
);

	state_t state_q;
	state_t state_d;

	// Hold the current state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = stat.run_bad ? ST_ERR : ST_SCAN;
			end
			ST_ERR: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.emit_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_DECIDE: begin
				cmd.scan_init = 1'b1;
			end
			ST_ERR: begin
				cmd.err_emit = 1'b1;
				cmd.clear    = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.emit_init = stat.scan_done;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				cmd.clear     = stat.emit_done;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/asf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module asf_datapath import asf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctl_cmd_t          cmd,
	input  wire logic [TIME_W-1:0] act_start,
	input  wire logic [TIME_W-1:0] act_finish,
	output dp_stat_t               stat,
	output logic                   out_strobe,
	output logic [TIME_W-1:0]      out_start,
	output logic [TIME_W-1:0]      out_finish,
	output logic [SELCNT_W-1:0]    selected_count,
	output logic                   out_last,
	output logic [1:0]             error_code
);

	// Sorted cell chain, ascending by finish
	logic [TIME_W-1:0] start_q  [MAX_ACT];
	logic [TIME_W-1:0] finish_q [MAX_ACT];
	logic [CNT_W-1:0]  count_q;
	err_t              err_q;

	// Selection walk
	logic [IDX_W-1:0]   idx_q;
	logic [TIME_W-1:0]  lastfin_q;
	logic [MAX_ACT-1:0] mark_q;
	logic [CNT_W-1:0]   nsel_q;
	logic [CNT_W-1:0]   emitted_q;

	// Output register
	logic                strobe_q;
	logic [TIME_W-1:0]   ostart_q;
	logic [TIME_W-1:0]   ofinish_q;
	logic [CNT_W-1:0]    ocount_q;
	logic                olast_q;
	err_t                oerr_q;

	logic               act_ok;
	logic               full;
	logic               do_insert;
	logic [MAX_ACT-1:0] occ;
	logic [MAX_ACT-1:0] gt;
	logic [TIME_W-1:0]  rd_start;
	logic [TIME_W-1:0]  rd_finish;
	logic               take;
	logic               emit_hit;

	assign act_ok    = act_start < act_finish;
	assign full      = count_q == CNT_W'(MAX_ACT);
	assign do_insert = cmd.load && act_ok && !full;

	// Compare the new finish against every held cell
	always_comb begin
		for (int i = 0; i < MAX_ACT; i++) begin
			occ[i] = CNT_W'(i) < count_q;
			gt[i]  = occ[i] && (finish_q[i] > act_finish);
		end
	end

	// Shift cells up past the insertion point and drop the new activity in
	always_ff @(posedge clk) begin
		if (do_insert) begin
			for (int i = 0; i < MAX_ACT; i++) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					start_q[i]  <= start_q[(i > 0) ? i - 1 : 0];
					finish_q[i] <= finish_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || CNT_W'(i) == count_q) begin
					start_q[i]  <= act_start;
					finish_q[i] <= act_finish;
				end
			end
		end
	end

	// Track fill level and the first error of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ERR_NONE;
		end else if (cmd.clear) begin
			count_q <= '0;
			err_q   <= ERR_NONE;
		end else if (cmd.load) begin
			if (!act_ok) begin
				if (err_q == ERR_NONE) err_q <= ERR_ORDER;
			end else if (full) begin
				if (err_q == ERR_NONE) err_q <= ERR_FULL;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Read the cell under the walk pointer
	assign rd_start  = start_q[idx_q];
	assign rd_finish = finish_q[idx_q];
	assign take      = (idx_q == '0) || (rd_start >= lastfin_q);
	assign emit_hit  = mark_q[idx_q];

	// Report run and walk status
	always_comb begin
		stat.run_bad   = (err_q != ERR_NONE) || (count_q == '0);
		stat.scan_done = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
		stat.emit_done = emit_hit && ((emitted_q + CNT_W'(1)) == nsel_q);
	end

	// Advance the greedy scan, then the emit walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			nsel_q    <= '0;
			emitted_q <= '0;
		end else if (cmd.scan_init) begin
			idx_q  <= '0;
			nsel_q <= '0;
		end else if (cmd.scan_step) begin
			if (take) nsel_q <= nsel_q + CNT_W'(1);
			if (cmd.emit_init) begin
				idx_q     <= '0;
				emitted_q <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end else if (cmd.emit_step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (emit_hit) emitted_q <= emitted_q + CNT_W'(1);
		end
	end

	// Mark kept cells and hold the finish of the latest one
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			mark_q[idx_q] <= take;
			if (take) lastfin_q <= rd_finish;
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.err_emit || (cmd.emit_step && emit_hit);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_emit) begin
			ostart_q  <= '0;
			ofinish_q <= '0;
			ocount_q  <= '0;
			olast_q   <= 1'b1;
			oerr_q    <= err_q;
		end else if (cmd.emit_step && emit_hit) begin
			ostart_q  <= rd_start;
			ofinish_q <= rd_finish;
			ocount_q  <= nsel_q;
			olast_q   <= stat.emit_done;
			oerr_q    <= ERR_NONE;
		end
	end

	assign out_strobe     = strobe_q;
	assign out_start      = ostart_q;
	assign out_finish     = ofinish_q;
	assign selected_count = SELCNT_W'(ocount_q);
	assign out_last       = olast_q;
	assign error_code     = oerr_q;

endmodule

`default_nettype wire

// ----- rtl/activity_selection_by_finish_top.sv -----
// Greedy activity selection by earliest finish time.
// Input: an activity (act_start, act_finish, last) is transferred at a
// rising edge where start is high and busy is low. Items that are not last
// go in back to back: a chain of 32 cells inserts each in finish order
// in the cycle it is transferred, so busy stays low between them.
// On the last item busy rises; the block passes a decide state, then marks
// kept activities in a greedy scan of the held cells through one cell read
// port, then walks the cells again, putting out one kept activity per marked
// cell. Each result is on the output ports for one cycle with out_strobe
// high; out_last marks the final one and selected_count carries the run's
// total on every result.
// An invalid activity (start not below finish) or a transfer into a full
// store makes the run end in one error result instead, put out from the
// error state. The receiver cannot stall: results must be taken as shown.
// Reset empties the store and clears any pending error; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module activity_selection_by_finish_top import asf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [TIME_W-1:0] act_start,
	input  wire logic [TIME_W-1:0] act_finish,
	input  wire logic              last,
	output logic                   out_strobe,
	output logic [TIME_W-1:0]      out_start,
	output logic [TIME_W-1:0]      out_finish,
	output logic [SELCNT_W-1:0]    selected_count,
	output logic                   out_last,
	output logic [1:0]             error_code
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequence the run
	asf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Hold, sort and select activities
	asf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.act_start      (act_start),
		.act_finish     (act_finish),
		.stat           (stat),
		.out_strobe     (out_strobe),
		.out_start      (out_start),
		.out_finish     (out_finish),
		.selected_count (selected_count),
		.out_last       (out_last),
		.error_code     (error_code)
	);

endmodule

`default_nettype wire
